### rtl/sbap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbap_pkg
// Types and constants shared by the shared-buffer admission and PFC block.
// ----------------------------------------------------------------------------
package sbap_pkg;

   localparam int ThrWidth     = 24;
   localparam int SizeWidth    = 16;
   localparam int PortWidth    = 4;
   localparam int MaskWidth    = 16;
   localparam int EventWidth   = 32;
   localparam int CsrIdxWidth  = 3;
   localparam int CsrDataWidth = 24;
   localparam int ReqDataWidth = 24;
   localparam int ReqUserWidth = 2;
   localparam int RspDataWidth = 80;
   localparam int RspPadWidth  = 7;

   localparam logic [ThrWidth-1:0] ThrMaxReset  = '1;
   localparam logic [ThrWidth-1:0] ThrZeroReset = '0;

   typedef enum logic [CsrIdxWidth-1:0] {
      REG_BUFFER_THR     = 3'd0,
      REG_PAUSE_THR      = 3'd1,
      REG_NIC_PAUSE_THR  = 3'd2,
      REG_RESUME_THR     = 3'd3,
      REG_NIC_RESUME_THR = 3'd4,
      REG_PFC_ENABLE     = 3'd5,
      REG_NIC_MASK       = 3'd6
   } csr_index_type;

   typedef enum logic {
      ACT_ARRIVAL   = 1'b0,
      ACT_DEPARTURE = 1'b1
   } action_type;

   typedef struct packed {
      logic [ThrWidth-1:0]  buffer_thr;
      logic [ThrWidth-1:0]  pause_thr;
      logic [ThrWidth-1:0]  nic_pause_thr;
      logic [ThrWidth-1:0]  resume_thr;
      logic [ThrWidth-1:0]  nic_resume_thr;
      logic                 pfc_enable;
      logic [MaskWidth-1:0] nic_mask;
   } cfg_type;

   typedef struct packed {
      action_type           action;
      logic [PortWidth-1:0] port;
      logic [SizeWidth-1:0] size;
      logic                 exempt;
   } item_type;

   typedef struct packed {
      logic                  admitted;
      logic                  dropped;
      logic                  send_pause;
      logic                  send_resume;
      logic [PortWidth-1:0]  flow_port;
      logic [EventWidth-1:0] drop_total;
      logic [EventWidth-1:0] pause_total;
      logic                  underflow;
   } result_type;

endpackage

### rtl/shared_buffer_admission_pfc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shared_buffer_admission_pfc
// Shared-buffer admission with per-port PFC pause / resume signalling.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_tvalid/req_tready | tdata port,size; tuser action,exempt
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata flags, flow_port, totals
//  csr     | in        | csr_valid/csr_ready   | csr_index, csr_wdata
//
//  One word per cycle sustained while rsp is not stalled.
//  Input register, then decision and state update, then result register.
//  Occupancy state is read and written in the same cycle, so words on the
//  same port follow each other with no bubble.
//  rsp stall holds the result register; req still takes one word behind it.
//  Synchronous reset clears all counters and pause flags; csr always ready.
// ----------------------------------------------------------------------------
module shared_buffer_admission_pfc #(
   parameter int NUM_PORTS   = 16,
   parameter int COUNT_WIDTH = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [3:0] port, [19:4] size, [23:20] zero
   input  logic [sbap_pkg::ReqDataWidth-1:0] req_tdata,
   // [0] action, [1] exempt
   input  logic [sbap_pkg::ReqUserWidth-1:0] req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] admitted, [1] dropped, [2] send_pause, [3] send_resume,
   // [7:4] flow_port, [39:8] drop_total, [71:40] pause_total,
   // [72] underflow, [79:73] zero
   output logic [sbap_pkg::RspDataWidth-1:0] rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sbap_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [sbap_pkg::CsrDataWidth-1:0] csr_wdata
);
   import sbap_pkg::*;

   cfg_type    cfg;
   item_type   req_item;
   item_type   item_ff;
   logic       item_valid_ff;
   result_type core_result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       advance;

   assign csr_ready = 1'b1;

   sbap_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   always_comb begin
      req_item.action = action_type'(req_tuser[0]);
      req_item.exempt = req_tuser[1];
      req_item.port   = req_tdata[PortWidth-1:0];
      req_item.size   = req_tdata[PortWidth +: SizeWidth];
   end

   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
   end

   sbap_core #(
      .NUM_PORTS   (NUM_PORTS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (item_ff),
      .commit (advance),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_tready) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RspPadWidth{1'b0}}, rsp_ff.underflow, rsp_ff.pause_total,
                        rsp_ff.drop_total, rsp_ff.flow_port, rsp_ff.send_resume,
                        rsp_ff.send_pause, rsp_ff.dropped, rsp_ff.admitted};

`ifndef SYNTHESIS
   a_adm_drop_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.admitted && rsp_ff.dropped))
      else $error("admitted and dropped both set");

   a_pause_resume_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.send_pause && rsp_ff.send_resume))
      else $error("pause and resume both set");

   a_flow_port_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.send_pause && !rsp_ff.send_resume)
         |-> (rsp_ff.flow_port == '0))
      else $error("flow_port set without pause or resume");

   a_progress: assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("pending word not moved to result register");

   a_pause_count: assert property (@(posedge clock) disable iff (reset)
      (advance && core_result.send_pause) |=>
         (rsp_ff.pause_total == $past(u_core.pause_count_ff) + 1'b1))
      else $error("pause count not advanced with pause");
`endif

endmodule

### rtl/sbap_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbap_csr
// Threshold, enable and NIC mask registers, written one word at a time.
// ----------------------------------------------------------------------------
module sbap_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_en,
   input  logic [sbap_pkg::CsrIdxWidth-1:0]  wr_index,
   input  logic [sbap_pkg::CsrDataWidth-1:0] wr_data,
   output sbap_pkg::cfg_type                 cfg
);
   import sbap_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_index_type'(wr_index))
            REG_BUFFER_THR:     cfg_in.buffer_thr     = wr_data[ThrWidth-1:0];
            REG_PAUSE_THR:      cfg_in.pause_thr      = wr_data[ThrWidth-1:0];
            REG_NIC_PAUSE_THR:  cfg_in.nic_pause_thr  = wr_data[ThrWidth-1:0];
            REG_RESUME_THR:     cfg_in.resume_thr     = wr_data[ThrWidth-1:0];
            REG_NIC_RESUME_THR: cfg_in.nic_resume_thr = wr_data[ThrWidth-1:0];
            REG_PFC_ENABLE:     cfg_in.pfc_enable     = wr_data[0];
            REG_NIC_MASK:       cfg_in.nic_mask       = wr_data[MaskWidth-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.buffer_thr     <= ThrMaxReset;
         cfg_ff.pause_thr      <= ThrMaxReset;
         cfg_ff.nic_pause_thr  <= ThrMaxReset;
         cfg_ff.resume_thr     <= ThrZeroReset;
         cfg_ff.nic_resume_thr <= ThrZeroReset;
         cfg_ff.pfc_enable     <= 1'b0;
         cfg_ff.nic_mask       <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/sbap_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbap_core
// Buffer occupancy state and the admission / pause / resume decision.
// State is updated on commit; the result is combinational from the word.
// ----------------------------------------------------------------------------
module sbap_core #(
   parameter int NUM_PORTS   = 16,
   parameter int COUNT_WIDTH = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sbap_pkg::cfg_type    cfg,
   input  sbap_pkg::item_type   item,
   input  logic                 commit,
   output sbap_pkg::result_type result
);
   import sbap_pkg::*;

   // only ports reachable through the 4-bit field need storage
   localparam int PortSpan  = 1 << PortWidth;
   localparam int Entries   = (NUM_PORTS < PortSpan) ? NUM_PORTS : PortSpan;
   localparam int IdxWidth  = $clog2(Entries);
   localparam int Depth     = 1 << IdxWidth;
   localparam int CmpWidth  = (COUNT_WIDTH + 1 > ThrWidth) ? COUNT_WIDTH + 1 : ThrWidth;
   localparam logic [CmpWidth-1:0] CountMax = CmpWidth'({COUNT_WIDTH{1'b1}});

   logic [COUNT_WIDTH-1:0] shared_ff;
   logic [COUNT_WIDTH-1:0] shared_in;
   logic [COUNT_WIDTH-1:0] port_bytes_ff [Depth];
   logic [COUNT_WIDTH-1:0] occ_in;
   logic [Depth-1:0]       paused_ff;
   logic                   paused_in;
   logic [EventWidth-1:0]  drop_count_ff;
   logic [EventWidth-1:0]  drop_count_in;
   logic [EventWidth-1:0]  pause_count_ff;
   logic [EventWidth-1:0]  pause_count_in;
   logic                   write_state;

   logic [IdxWidth-1:0]    idx;
   logic                   skip;
   logic                   is_nic;
   logic [COUNT_WIDTH-1:0] occ_cur;
   logic [COUNT_WIDTH-1:0] size_ext;
   logic [CmpWidth-1:0]    shared_sum;
   logic [CmpWidth-1:0]    occ_sum;
   logic [CmpWidth-1:0]    occ_cmp;
   logic                   shared_under;
   logic                   occ_under;

   always_comb begin
      idx          = item.port[IdxWidth-1:0];
      skip         = item.exempt || (32'(item.port) >= NUM_PORTS);
      is_nic       = cfg.nic_mask[item.port];
      occ_cur      = port_bytes_ff[idx];
      size_ext     = COUNT_WIDTH'(item.size);
      shared_sum   = CmpWidth'(shared_ff) + CmpWidth'(item.size);
      occ_sum      = CmpWidth'(occ_cur) + CmpWidth'(item.size);
      shared_under = size_ext > shared_ff;
      occ_under    = size_ext > occ_cur;

      shared_in      = shared_ff;
      occ_in         = occ_cur;
      paused_in      = paused_ff[idx];
      drop_count_in  = drop_count_ff;
      pause_count_in = pause_count_ff;
      write_state    = 1'b0;
      occ_cmp        = '0;
      result         = '0;
      result.drop_total  = drop_count_ff;
      result.pause_total = pause_count_ff;

      if (item.action == ACT_ARRIVAL) begin
         if (skip) begin
            result.admitted = 1'b1;
         end else if (shared_sum > CmpWidth'(cfg.buffer_thr)) begin
            drop_count_in     = drop_count_ff + 1'b1;
            result.dropped    = 1'b1;
            result.drop_total = drop_count_in;
         end else begin
            write_state     = 1'b1;
            result.admitted = 1'b1;
            shared_in = (shared_sum > CountMax) ? CountMax[COUNT_WIDTH-1:0]
                                                : shared_sum[COUNT_WIDTH-1:0];
            occ_in    = (occ_sum > CountMax) ? CountMax[COUNT_WIDTH-1:0]
                                             : occ_sum[COUNT_WIDTH-1:0];
            occ_cmp   = CmpWidth'(occ_in);
            if (cfg.pfc_enable && !paused_ff[idx] &&
                ((occ_cmp > CmpWidth'(cfg.pause_thr)) ||
                 (is_nic && (occ_cmp > CmpWidth'(cfg.nic_pause_thr))))) begin
               pause_count_in     = pause_count_ff + 1'b1;
               paused_in          = 1'b1;
               result.send_pause  = 1'b1;
               result.flow_port   = item.port;
               result.pause_total = pause_count_in;
            end
         end
      end else if (!skip) begin
         write_state      = 1'b1;
         shared_in        = shared_under ? '0 : shared_ff - size_ext;
         occ_in           = occ_under ? '0 : occ_cur - size_ext;
         occ_cmp          = CmpWidth'(occ_in);
         result.underflow = shared_under || occ_under;
         if (paused_ff[idx] &&
             ((occ_cmp < CmpWidth'(cfg.nic_resume_thr)) ||
              (!is_nic && (occ_cmp < CmpWidth'(cfg.resume_thr))))) begin
            paused_in          = 1'b0;
            result.send_resume = 1'b1;
            result.flow_port   = item.port;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shared_ff      <= '0;
         paused_ff      <= '0;
         drop_count_ff  <= '0;
         pause_count_ff <= '0;
         for (int i = 0; i < Depth; i++) begin
            port_bytes_ff[i] <= '0;
         end
      end else if (commit) begin
         drop_count_ff  <= drop_count_in;
         pause_count_ff <= pause_count_in;
         if (write_state) begin
            shared_ff          <= shared_in;
            port_bytes_ff[idx] <= occ_in;
            paused_ff[idx]     <= paused_in;
         end
      end
   end

endmodule
